// ===== rtl/msp_pkg.sv =====
// ---------------------------------------------------------------------------
// msp_pkg: shared types and width helpers
// Case codes and the width rules that tie the datapath to the coordinate width.
// ---------------------------------------------------------------------------
`default_nettype none

package msp_pkg;

	localparam int COORD_BITS_DEF = 16;

	typedef enum logic [1:0] {
		SEL_P1P2 = 2'd0,
		SEL_P1P0 = 2'd1,
		SEL_P2P0 = 2'd2,
		SEL_CIRC = 2'd3
	} sel_t;

	// coordinate difference
	function automatic int dfw_f(input int cb);
		return cb + 1;
	endfunction

	// squared side length
	function automatic int sqw_f(input int cb);
		return 2 * (cb + 1);
	endfunction

	// squared cross product norm
	function automatic int xsw_f(input int cb);
		return 4 * (cb + 1);
	endfunction

	// center divisor (four times the cross norm)
	function automatic int cdw_f(input int cb);
		return xsw_f(cb) + 2;
	endfunction

	// center quotient bits
	function automatic int qcw_f(input int cb);
		return cb + 2;
	endfunction

	// center partial remainder
	function automatic int cnw_f(input int cb);
		return cdw_f(cb) + qcw_f(cb);
	endfunction

	// radius quotient bits
	function automatic int qrw_f(input int cb);
		return 2 * cb + 4;
	endfunction

	// radius partial remainder
	function automatic int rnw_f(input int cb);
		return xsw_f(cb) + qrw_f(cb);
	endfunction

	// square root result bits
	function automatic int rtw_f(input int cb);
		return cb + 2;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/msp_delay.sv =====
// ---------------------------------------------------------------------------
// msp_delay: payload delay line
// Fixed-length shift line that keeps side data aligned with the cell chains.
// ---------------------------------------------------------------------------
`default_nettype none

module msp_delay #(
	parameter int W = 8,
	parameter int N = 2
) (
	input  wire          clk,
	input  wire          en,
	input  wire  [W-1:0] d_i,
	output logic [W-1:0] d_o
);

	logic [W-1:0] line_q [N];

	always_ff @(posedge clk) begin
		if (en) begin
			line_q[0] <= d_i;
			for (int i = 1; i < N; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign d_o = line_q[N-1];

endmodule

`default_nettype wire

// ===== rtl/msp_div_cell.sv =====
// ---------------------------------------------------------------------------
// msp_div_cell: one restoring division cell
// Try the divisor at one fixed weight, subtract when it fits, set that bit.
// ---------------------------------------------------------------------------
`default_nettype none

module msp_div_cell #(
	parameter int NW = 16,
	parameter int DW = 8,
	parameter int QW = 8,
	parameter int SH = 0
) (
	input  wire           clk,
	input  wire           en,
	input  wire  [NW-1:0] rem_i,
	input  wire  [DW-1:0] den_i,
	input  wire  [QW-1:0] q_i,
	output logic [NW-1:0] rem_o,
	output logic [DW-1:0] den_o,
	output logic [QW-1:0] q_o
);

	logic [NW-1:0] dsh;
	logic [NW:0]   diff;
	logic          ge;

	assign dsh  = NW'(den_i) << SH;
	assign diff = {1'b0, rem_i} - {1'b0, dsh};
	assign ge   = !diff[NW];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= ge ? diff[NW-1:0] : rem_i;
			den_o <= den_i;
			q_o   <= ge ? (q_i | (QW'(1) << SH)) : q_i;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/msp_sqrt_cell.sv =====
// ---------------------------------------------------------------------------
// msp_sqrt_cell: one digit of the integer square root
// Settle one root bit per cell with the shift-and-subtract recurrence.
// ---------------------------------------------------------------------------
`default_nettype none

module msp_sqrt_cell #(
	parameter int W   = 16,
	parameter int IDX = 0
) (
	input  wire          clk,
	input  wire          en,
	input  wire  [W-1:0] num_i,
	input  wire  [W-1:0] res_i,
	output logic [W-1:0] num_o,
	output logic [W-1:0] res_o
);

	logic [W-1:0] bitv;
	logic [W:0]   trial;
	logic         ge;

	assign bitv  = W'(1) << (2 * IDX);
	assign trial = {1'b0, res_i} + {1'b0, bitv};
	assign ge    = {1'b0, num_i} >= trial;

	always_ff @(posedge clk) begin
		if (en) begin
			num_o <= ge ? (num_i - trial[W-1:0]) : num_i;
			res_o <= ge ? ((res_i >> 1) + bitv) : (res_i >> 1);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/msp_front.sv =====
// ---------------------------------------------------------------------------
// msp_front: geometry front end
// Sides, dot and cross products, case pick and divider operands in six stages.
// ---------------------------------------------------------------------------
`default_nettype none

module msp_front #(
	parameter int CB = msp_pkg::COORD_BITS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  en,
	input  wire                                  in_valid,
	input  wire signed [CB-1:0]                  p0_x,
	input  wire signed [CB-1:0]                  p0_y,
	input  wire signed [CB-1:0]                  p0_z,
	input  wire signed [CB-1:0]                  p1_x,
	input  wire signed [CB-1:0]                  p1_y,
	input  wire signed [CB-1:0]                  p1_z,
	input  wire signed [CB-1:0]                  p2_x,
	input  wire signed [CB-1:0]                  p2_y,
	input  wire signed [CB-1:0]                  p2_z,
	output logic                                 v_o,
	output msp_pkg::sel_t                        sel_o,
	output logic [msp_pkg::sqw_f(CB)-1:0]        side_sq_o,
	output logic [CB-1:0]                        mid_o [3],
	output logic [CB-1:0]                        p0_o [3],
	output logic [2:0]                           neg_o,
	output logic [msp_pkg::cnw_f(CB)-1:0]        cnum_o [3],
	output logic [msp_pkg::cdw_f(CB)-1:0]        cden_o,
	output logic [msp_pkg::rnw_f(CB)-1:0]        rnum_o,
	output logic [msp_pkg::xsw_f(CB)-1:0]        rden_o
);
	import msp_pkg::*;

	localparam int DFW = dfw_f(CB);
	localparam int SQW = sqw_f(CB);
	localparam int DTW = 2 * DFW + 1;
	localparam int XW  = 2 * DFW;
	localparam int XSW = xsw_f(CB);
	localparam int WW  = DTW + SQW;
	localparam int TW  = WW + DFW;
	localparam int NPW = TW + 3;
	localparam int CNW = cnw_f(CB);
	localparam int CDW = cdw_f(CB);
	localparam int RNW = rnw_f(CB);
	localparam logic signed [CB+1:0] ONE_M = 1;

	logic signed [CB-1:0] p [3][3];

	assign p[0][0] = p0_x;
	assign p[0][1] = p0_y;
	assign p[0][2] = p0_z;
	assign p[1][0] = p1_x;
	assign p[1][1] = p1_y;
	assign p[1][2] = p1_z;
	assign p[2][0] = p2_x;
	assign p[2][1] = p2_y;
	assign p[2][2] = p2_z;

	// stage 1: side vectors
	logic                  v_s1;
	logic signed [CB-1:0]  p_s1 [3][3];
	logic signed [DFW-1:0] a_s1 [3];
	logic signed [DFW-1:0] b_s1 [3];
	logic signed [DFW-1:0] c_s1 [3];

	// stage 2: squares, dots, cross
	logic                  v_s2;
	logic signed [CB-1:0]  p_s2 [3][3];
	logic [SQW-1:0]        asq_s2, bsq_s2, csq_s2;
	logic signed [DTW-1:0] ca_s2, ba_s2;
	logic signed [XW-1:0]  x_s2 [3];
	logic signed [DFW-1:0] b_s2 [3];
	logic signed [DFW-1:0] c_s2 [3];

	// stage 3: case pick, weights, norms
	logic                  v_s3;
	sel_t                  sel_s3;
	logic [SQW-1:0]        side_s3, csq_s3;
	logic [CB-1:0]         mid_s3 [3];
	logic [CB-1:0]         p0_s3 [3];
	logic signed [WW-1:0]  u1_s3, u2_s3;
	logic [XSW-1:0]        xn_s3;
	logic [2*SQW-1:0]      m_s3;
	logic signed [DFW-1:0] b_s3 [3];
	logic signed [DFW-1:0] c_s3 [3];

	// stage 4: weighted offsets, radius partial products
	logic                  v_s4;
	sel_t                  sel_s4;
	logic [SQW-1:0]        side_s4;
	logic [CB-1:0]         mid_s4 [3];
	logic [CB-1:0]         p0_s4 [3];
	logic signed [TW-1:0]  t1_s4 [3];
	logic signed [TW-1:0]  t2_s4 [3];
	logic [XSW-1:0]        xn_s4;
	logic [2*SQW-1:0]      pplo_s4, pphi_s4;

	// stage 5: rounded numerators
	logic                  v_s5;
	sel_t                  sel_s5;
	logic [SQW-1:0]        side_s5;
	logic [CB-1:0]         mid_s5 [3];
	logic [CB-1:0]         p0_s5 [3];
	logic signed [NPW-1:0] nump_s5 [3];
	logic [XSW-1:0]        xn_s5;
	logic [3*SQW-1:0]      pnum_s5;

	// stage 6: magnitudes for the dividers
	logic                  v_s6;
	sel_t                  sel_s6;
	logic [SQW-1:0]        side_s6;
	logic [CB-1:0]         mid_s6 [3];
	logic [CB-1:0]         p0_s6 [3];
	logic [2:0]            neg_s6;
	logic [CNW-1:0]        cnum_s6 [3];
	logic [XSW-1:0]        xn_s6;
	logic [RNW-1:0]        rnum_s6;

	logic [SQW:0]          s_cb, s_ab, s_ac;
	sel_t                  sel_c;
	logic signed [CB+1:0]  msum [3];
	logic signed [NPW-1:0] nabs [3];

	assign s_cb = csq_s2 + bsq_s2;
	assign s_ab = asq_s2 + bsq_s2;
	assign s_ac = asq_s2 + csq_s2;

	// ties fall to the earliest side test
	always_comb begin
		if (s_cb <= {1'b0, asq_s2}) begin
			sel_c = SEL_P1P2;
		end else if (s_ab <= {1'b0, csq_s2}) begin
			sel_c = SEL_P1P0;
		end else if (s_ac <= {1'b0, bsq_s2}) begin
			sel_c = SEL_P2P0;
		end else begin
			sel_c = SEL_CIRC;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			case (sel_c)
				SEL_P1P2: msum[k] = p_s2[1][k] + p_s2[2][k] + ONE_M;
				SEL_P1P0: msum[k] = p_s2[1][k] + p_s2[0][k] + ONE_M;
				default:  msum[k] = p_s2[2][k] + p_s2[0][k] + ONE_M;
			endcase
			nabs[k] = nump_s5[k][NPW-1] ? -nump_s5[k] : nump_s5[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= p;
			for (int k = 0; k < 3; k++) begin
				a_s1[k] <= p[1][k] - p[2][k];
				b_s1[k] <= p[2][k] - p[0][k];
				c_s1[k] <= p[0][k] - p[1][k];
			end

			p_s2   <= p_s1;
			b_s2   <= b_s1;
			c_s2   <= c_s1;
			asq_s2 <= a_s1[0] * a_s1[0] + a_s1[1] * a_s1[1] + a_s1[2] * a_s1[2];
			bsq_s2 <= b_s1[0] * b_s1[0] + b_s1[1] * b_s1[1] + b_s1[2] * b_s1[2];
			csq_s2 <= c_s1[0] * c_s1[0] + c_s1[1] * c_s1[1] + c_s1[2] * c_s1[2];
			ca_s2  <= c_s1[0] * a_s1[0] + c_s1[1] * a_s1[1] + c_s1[2] * a_s1[2];
			ba_s2  <= b_s1[0] * a_s1[0] + b_s1[1] * a_s1[1] + b_s1[2] * a_s1[2];
			x_s2[0] <= a_s1[1] * c_s1[2] - a_s1[2] * c_s1[1];
			x_s2[1] <= a_s1[2] * c_s1[0] - a_s1[0] * c_s1[2];
			x_s2[2] <= a_s1[0] * c_s1[1] - a_s1[1] * c_s1[0];

			sel_s3 <= sel_c;
			case (sel_c)
				SEL_P1P2: side_s3 <= asq_s2;
				SEL_P1P0: side_s3 <= csq_s2;
				default:  side_s3 <= bsq_s2;
			endcase
			csq_s3 <= csq_s2;
			b_s3   <= b_s2;
			c_s3   <= c_s2;
			for (int k = 0; k < 3; k++) begin
				mid_s3[k] <= msum[k][CB:1];
				p0_s3[k]  <= p_s2[0][k];
			end
			u1_s3 <= ca_s2 * $signed({1'b0, bsq_s2});
			u2_s3 <= ba_s2 * $signed({1'b0, csq_s2});
			xn_s3 <= x_s2[0] * x_s2[0] + x_s2[1] * x_s2[1] + x_s2[2] * x_s2[2];
			m_s3  <= asq_s2 * bsq_s2;

			sel_s4  <= sel_s3;
			side_s4 <= side_s3;
			mid_s4  <= mid_s3;
			p0_s4   <= p0_s3;
			xn_s4   <= xn_s3;
			for (int k = 0; k < 3; k++) begin
				t1_s4[k] <= u1_s3 * c_s3[k];
				t2_s4[k] <= u2_s3 * b_s3[k];
			end
			pplo_s4 <= m_s3[SQW-1:0] * csq_s3;
			pphi_s4 <= m_s3[2*SQW-1:SQW] * csq_s3;

			sel_s5  <= sel_s4;
			side_s5 <= side_s4;
			mid_s5  <= mid_s4;
			p0_s5   <= p0_s4;
			xn_s5   <= xn_s4;
			for (int k = 0; k < 3; k++) begin
				nump_s5[k] <= ((t1_s4[k] - t2_s4[k]) <<< 1) + $signed({1'b0, xn_s4, 1'b0});
			end
			pnum_s5 <= {pphi_s4, {SQW{1'b0}}} + pplo_s4;

			sel_s6  <= sel_s5;
			side_s6 <= side_s5;
			mid_s6  <= mid_s5;
			p0_s6   <= p0_s5;
			xn_s6   <= xn_s5;
			rnum_s6 <= RNW'(pnum_s5);
			for (int k = 0; k < 3; k++) begin
				neg_s6[k]  <= nump_s5[k][NPW-1];
				cnum_s6[k] <= nabs[k][CNW-1:0];
			end
		end
	end

	assign v_o       = v_s6;
	assign sel_o     = sel_s6;
	assign side_sq_o = side_s6;
	assign mid_o     = mid_s6;
	assign p0_o      = p0_s6;
	assign neg_o     = neg_s6;
	assign cnum_o    = cnum_s6;
	assign cden_o    = {xn_s6, 2'b00};
	assign rnum_o    = rnum_s6;
	assign rden_o    = xn_s6;

endmodule

`default_nettype wire

// ===== rtl/min_sphere_three_points_top.sv =====
// ---------------------------------------------------------------------------
// min_sphere_three_points_top: smallest sphere around three 3D points
// Front end, chains of division and root cells, output register.
// ---------------------------------------------------------------------------
//
//  channel  handshake            word
//  -------  -------------------  --------------------------------------------
//  input    in_valid / in_stall  p0_x..p2_z, signed Q8.8 points
//  output   out_valid / out_stall center_x/y/z, sphere_radius, case_taken
//
// One word enters per cycle while in_stall is low. A word passes from input to
// output through six front-end stages, then the radius quotient chain (one bit
// per cell) followed by the root chain (one bit per cell), then the output
// register. The center quotients run in parallel on shorter chains.
// Reset clears only the valid flags. A stall on the output while a word waits
// freezes the whole pipeline and raises in_stall in the same cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module min_sphere_three_points_top #(
	parameter int COORD_BITS = msp_pkg::COORD_BITS_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	output logic                        in_stall,
	input  wire signed [COORD_BITS-1:0] p0_x,
	input  wire signed [COORD_BITS-1:0] p0_y,
	input  wire signed [COORD_BITS-1:0] p0_z,
	input  wire signed [COORD_BITS-1:0] p1_x,
	input  wire signed [COORD_BITS-1:0] p1_y,
	input  wire signed [COORD_BITS-1:0] p1_z,
	input  wire signed [COORD_BITS-1:0] p2_x,
	input  wire signed [COORD_BITS-1:0] p2_y,
	input  wire signed [COORD_BITS-1:0] p2_z,
	output logic                        out_valid,
	input  wire                         out_stall,
	output logic signed [COORD_BITS-1:0] center_x,
	output logic signed [COORD_BITS-1:0] center_y,
	output logic signed [COORD_BITS-1:0] center_z,
	output logic [COORD_BITS:0]         sphere_radius,
	output msp_pkg::sel_t               case_taken
);
	import msp_pkg::*;

	localparam int CB  = COORD_BITS;
	localparam int SQW = sqw_f(CB);
	localparam int XSW = xsw_f(CB);
	localparam int CDW = cdw_f(CB);
	localparam int CNW = cnw_f(CB);
	localparam int QCW = qcw_f(CB);
	localparam int QRW = qrw_f(CB);
	localparam int RNW = rnw_f(CB);
	localparam int RTW = rtw_f(CB);
	localparam int LB  = QRW + RTW;
	localparam int LC  = LB - QCW;
	localparam int BW  = 2 + 3 + 6 * CB;
	localparam int CW  = 3 * (QCW + 1);
	localparam int AW  = 1 + SQW;

	logic en;

	// hold everything while a finished word is refused downstream
	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	// front end
	logic           f_v;
	sel_t           f_sel;
	logic [SQW-1:0] f_side;
	logic [CB-1:0]  f_mid [3];
	logic [CB-1:0]  f_p0 [3];
	logic [2:0]     f_neg;
	logic [CNW-1:0] f_cnum [3];
	logic [CDW-1:0] f_cden;
	logic [RNW-1:0] f_rnum;
	logic [XSW-1:0] f_rden;

	msp_front #(.CB(CB)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.p0_x      (p0_x),
		.p0_y      (p0_y),
		.p0_z      (p0_z),
		.p1_x      (p1_x),
		.p1_y      (p1_y),
		.p1_z      (p1_z),
		.p2_x      (p2_x),
		.p2_y      (p2_y),
		.p2_z      (p2_z),
		.v_o       (f_v),
		.sel_o     (f_sel),
		.side_sq_o (f_side),
		.mid_o     (f_mid),
		.p0_o      (f_p0),
		.neg_o     (f_neg),
		.cnum_o    (f_cnum),
		.cden_o    (f_cden),
		.rnum_o    (f_rnum),
		.rden_o    (f_rden)
	);

	// center quotient chains, one per axis, MSB first
	logic [CNW-1:0] crem [3][QCW+1];
	logic [CDW-1:0] cden [3][QCW+1];
	logic [QCW-1:0] cq   [3][QCW+1];

	for (genvar k = 0; k < 3; k++) begin : g_clane
		assign crem[k][0] = f_cnum[k];
		assign cden[k][0] = f_cden;
		assign cq[k][0]   = '0;
		for (genvar i = 0; i < QCW; i++) begin : g_cell
			msp_div_cell #(.NW(CNW), .DW(CDW), .QW(QCW), .SH(QCW - 1 - i)) u_cell (
				.clk   (clk),
				.en    (en),
				.rem_i (crem[k][i]),
				.den_i (cden[k][i]),
				.q_i   (cq[k][i]),
				.rem_o (crem[k][i+1]),
				.den_o (cden[k][i+1]),
				.q_o   (cq[k][i+1])
			);
		end
	end

	// radius quotient chain: product of squared sides over squared cross norm
	logic [RNW-1:0] rrem [QRW+1];
	logic [XSW-1:0] rden [QRW+1];
	logic [QRW-1:0] rq   [QRW+1];

	assign rrem[0] = f_rnum;
	assign rden[0] = f_rden;
	assign rq[0]   = '0;

	for (genvar i = 0; i < QRW; i++) begin : g_rcell
		msp_div_cell #(.NW(RNW), .DW(XSW), .QW(QRW), .SH(QRW - 1 - i)) u_cell (
			.clk   (clk),
			.en    (en),
			.rem_i (rrem[i]),
			.den_i (rden[i]),
			.q_i   (rq[i]),
			.rem_o (rrem[i+1]),
			.den_o (rden[i+1]),
			.q_o   (rq[i+1])
		);
	end

	// side case and squared side, aligned with the radius quotient
	logic [AW-1:0]  a_in, a_out;
	logic           circ_a;
	logic [SQW-1:0] side_a;

	assign a_in = {f_sel == SEL_CIRC, f_side};

	msp_delay #(.W(AW), .N(QRW)) u_dly_a (
		.clk (clk),
		.en  (en),
		.d_i (a_in),
		.d_o (a_out)
	);

	assign {circ_a, side_a} = a_out;

	// root chain: the radius is the nearest integer to half the root
	logic [QRW-1:0] snum [RTW+1];
	logic [QRW-1:0] sres [RTW+1];

	assign snum[0] = circ_a ? rq[QRW] : QRW'(side_a);
	assign sres[0] = '0;

	for (genvar i = 0; i < RTW; i++) begin : g_scell
		msp_sqrt_cell #(.W(QRW), .IDX(RTW - 1 - i)) u_cell (
			.clk   (clk),
			.en    (en),
			.num_i (snum[i]),
			.res_i (sres[i]),
			.num_o (snum[i+1]),
			.res_o (sres[i+1])
		);
	end

	// case, signs, midpoint and base point, aligned with the root
	logic [BW-1:0] b_in, b_out;
	logic [1:0]    sel_b;
	logic [2:0]    neg_b;
	logic [CB-1:0] mid_b [3];
	logic [CB-1:0] p0_b [3];

	assign b_in = {f_sel, f_neg, f_mid[2], f_mid[1], f_mid[0], f_p0[2], f_p0[1], f_p0[0]};

	msp_delay #(.W(BW), .N(LB)) u_dly_b (
		.clk (clk),
		.en  (en),
		.d_i (b_in),
		.d_o (b_out)
	);

	assign {sel_b, neg_b, mid_b[2], mid_b[1], mid_b[0], p0_b[2], p0_b[1], p0_b[0]} = b_out;

	// center quotients and nonzero remainders, aligned with the root
	logic [CW-1:0]  c_in, c_out;
	logic [QCW-1:0] q_c [3];
	logic [2:0]     nz_c;

	assign c_in = {cq[2][QCW], crem[2][QCW] != '0,
	               cq[1][QCW], crem[1][QCW] != '0,
	               cq[0][QCW], crem[0][QCW] != '0};

	msp_delay #(.W(CW), .N(LC)) u_dly_c (
		.clk (clk),
		.en  (en),
		.d_i (c_in),
		.d_o (c_out)
	);

	assign {q_c[2], nz_c[2], q_c[1], nz_c[1], q_c[0], nz_c[0]} = c_out;

	// valid flags along the back end
	logic [LB-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LB-2:0], f_v};
		end
	end

	// final assembly: a negative numerator floors away from zero
	logic                 circ_b;
	logic signed [QCW+1:0] qm [3];
	logic signed [QCW+1:0] qs [3];
	logic [CB-1:0]        cen [3];
	logic [RTW:0]         rsum;

	assign circ_b = sel_b == SEL_CIRC;
	assign rsum   = {1'b0, sres[RTW][RTW-1:0]} + (RTW+1)'(1);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			qm[k]  = $signed({2'b00, q_c[k]})
			       + $signed({{(QCW + 1){1'b0}}, nz_c[k] & neg_b[k]});
			qs[k]  = neg_b[k] ? -qm[k] : qm[k];
			cen[k] = circ_b ? (p0_b[k] + qs[k][CB-1:0]) : mid_b[k];
		end
	end

	// output register
	logic                 out_valid_q;
	logic [CB-1:0]        center_x_q, center_y_q, center_z_q;
	logic [CB:0]          radius_q;
	sel_t                 case_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_q[LB-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			center_x_q <= cen[0];
			center_y_q <= cen[1];
			center_z_q <= cen[2];
			radius_q   <= rsum[CB+1:1];
			case_q     <= sel_t'(sel_b);
		end
	end

	assign out_valid     = out_valid_q;
	assign center_x      = center_x_q;
	assign center_y      = center_y_q;
	assign center_z      = center_z_q;
	assign sphere_radius = radius_q;
	assign case_taken    = case_q;

endmodule

`default_nettype wire
